>>> rtl/core/sdr_pkg.sv
// ----------------------------------------------------------------------------
// sdr_pkg
// Types, register indexes and constants shared by the solar duty ramp
// controller modules.
// ----------------------------------------------------------------------------
`default_nettype none

package sdr_pkg;

   localparam int unsigned UPDATE_SHIFT = 4;
   localparam int unsigned PHASE_W      = UPDATE_SHIFT;

   localparam int unsigned CSR_INDEX_W  = 3;
   localparam int unsigned CSR_DATA_W   = 32;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_START_LEVEL    = 3'd0,
      CSR_STOP_LEVEL     = 3'd1,
      CSR_FAN_TEMP       = 3'd2,
      CSR_TRIP_TEMP      = 3'd3,
      CSR_ENERGY_CEILING = 3'd4,
      CSR_MAX_ON         = 3'd5,
      CSR_HALF_PERIOD    = 3'd6
   } csr_index_type;

   localparam logic [7:0]  START_LEVEL_RST    = 8'd161;
   localparam logic [7:0]  STOP_LEVEL_RST     = 8'd69;
   localparam logic [7:0]  FAN_TEMP_RST       = 8'd170;
   localparam logic [7:0]  TRIP_TEMP_RST      = 8'd175;
   localparam logic [31:0] ENERGY_CEILING_RST = 32'd100000000;
   localparam logic [7:0]  MAX_ON_RST         = 8'd67;
   localparam logic [7:0]  HALF_PERIOD_RST    = 8'd100;

   // active-low LED bar codes
   localparam logic [3:0] LED_FULL  = 4'h0;
   localparam logic [3:0] LED_HIGH  = 4'h1;
   localparam logic [3:0] LED_MID   = 4'h3;
   localparam logic [3:0] LED_LOW   = 4'h7;
   localparam logic [3:0] LED_EMPTY = 4'hf;

   // x / 10 for 8-bit x as (x * 205) >> 11
   localparam logic [7:0] DIV10_MUL   = 8'd205;
   localparam int unsigned DIV10_SHIFT = 11;

   typedef struct packed {
      logic [7:0]  start_level;
      logic [7:0]  stop_level;
      logic [7:0]  fan_temp;
      logic [7:0]  trip_temp;
      logic [31:0] energy_ceiling;
      logic [7:0]  max_on;
      logic [7:0]  half_period;
   } cfg_type;

   typedef struct packed {
      logic [7:0] on_time;
      logic [7:0] off_time;
      logic       fan_run;
      logic [3:0] led_bar;
   } result_type;

endpackage

`default_nettype wire

>>> rtl/core/sdr_cfg.sv
// ----------------------------------------------------------------------------
// sdr_cfg
// Configuration register file, written through the csr port.
// ----------------------------------------------------------------------------
`default_nettype none

module sdr_cfg
   import sdr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_START_LEVEL:    cfg_in.start_level    = csr_wdata[7:0];
            CSR_STOP_LEVEL:     cfg_in.stop_level     = csr_wdata[7:0];
            CSR_FAN_TEMP:       cfg_in.fan_temp       = csr_wdata[7:0];
            CSR_TRIP_TEMP:      cfg_in.trip_temp      = csr_wdata[7:0];
            CSR_ENERGY_CEILING: cfg_in.energy_ceiling = csr_wdata[31:0];
            CSR_MAX_ON:         cfg_in.max_on         = csr_wdata[7:0];
            CSR_HALF_PERIOD:    cfg_in.half_period    = csr_wdata[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_level    <= START_LEVEL_RST;
         cfg_ff.stop_level     <= STOP_LEVEL_RST;
         cfg_ff.fan_temp       <= FAN_TEMP_RST;
         cfg_ff.trip_temp      <= TRIP_TEMP_RST;
         cfg_ff.energy_ceiling <= ENERGY_CEILING_RST;
         cfg_ff.max_on         <= MAX_ON_RST;
         cfg_ff.half_period    <= HALF_PERIOD_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

>>> rtl/core/sdr_core.sv
// ----------------------------------------------------------------------------
// sdr_core
// Per-cycle duty update: phase counter, ramp, trip, clamp, fan, LED bar and
// energy accumulation.
// ----------------------------------------------------------------------------
`default_nettype none

module sdr_core
   import sdr_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       step,
   input  wire logic [7:0] solar_sample,
   input  wire logic [7:0] temp_sample,
   input  cfg_type         cfg,
   output result_type      result
);

   logic [PHASE_W-1:0] cycle_phase_ff, cycle_phase_in;
   logic [7:0]         duty_ff, duty_in;
   logic [31:0]        energy_total_ff, energy_total_in;
   logic [7:0]         prior_temp_ff, prior_temp_in;

   logic [7:0]  cap;
   logic [7:0]  ramped;
   logic [7:0]  tripped;
   logic        trip;
   logic [15:0] cap_mul10;
   logic [7:0]  cap_tenth;
   logic [9:0]  cap_x3;
   logic [7:0]  cap_3q;
   logic [32:0] energy_sum;
   logic        fan;
   logic [3:0]  led;

   assign cap            = (cfg.max_on < cfg.half_period) ? cfg.max_on : cfg.half_period;
   assign cycle_phase_in = cycle_phase_ff + 1'b1;

   always_comb begin
      ramped = duty_ff;
      if (cycle_phase_in == '0) begin
         if (solar_sample < cfg.start_level) begin
            if (duty_ff != 8'd0) begin
               ramped = duty_ff - 8'd1;
            end
         end else if (duty_ff < cap) begin
            ramped = duty_ff + 8'd1;
         end
      end
   end

   assign trip = (solar_sample < cfg.stop_level) || (prior_temp_ff > cfg.trip_temp) ||
                 (energy_total_ff > cfg.energy_ceiling);
   assign tripped = trip ? 8'd0 : ramped;

   assign cap_mul10 = cap * DIV10_MUL;
   assign cap_tenth = 8'(cap_mul10 >> DIV10_SHIFT);
   assign fan       = (solar_sample > cfg.stop_level) && (tripped > cap_tenth) &&
                      (prior_temp_ff > cfg.fan_temp);

   assign duty_in = (tripped > cap) ? cap : tripped;

   assign cap_x3 = {2'b00, cap} + {1'b0, cap, 1'b0};
   assign cap_3q = cap_x3[9:2];

   always_comb begin
      priority if (duty_in == cap) begin
         led = LED_FULL;
      end else if (duty_in > cap_3q) begin
         led = LED_HIGH;
      end else if (duty_in > {1'b0, cap[7:1]}) begin
         led = LED_MID;
      end else if (duty_in > {2'b00, cap[7:2]}) begin
         led = LED_LOW;
      end else begin
         led = LED_EMPTY;
      end
   end

   assign energy_sum      = {1'b0, energy_total_ff} + {25'd0, duty_in};
   assign energy_total_in = energy_sum[32] ? '1 : energy_sum[31:0];
   assign prior_temp_in   = temp_sample;

   always_ff @(posedge clock) begin
      if (reset) begin
         cycle_phase_ff  <= '0;
         duty_ff         <= '0;
         energy_total_ff <= '0;
         prior_temp_ff   <= '0;
      end else if (step) begin
         cycle_phase_ff  <= cycle_phase_in;
         duty_ff         <= duty_in;
         energy_total_ff <= energy_total_in;
         prior_temp_ff   <= prior_temp_in;
      end
   end

   assign result.on_time  = duty_in;
   assign result.off_time = cfg.half_period - duty_in;
   assign result.fan_run  = fan;
   assign result.led_bar  = led;

   a_on_within_cap: assert property (@(posedge clock) disable iff (reset)
      duty_in <= cap)
      else $error("on time above cap");

   a_trip_forces_off: assert property (@(posedge clock) disable iff (reset)
      trip |-> (duty_in == 8'd0) && !fan)
      else $error("trip did not force output off");

   a_energy_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> energy_total_ff >= $past(energy_total_ff))
      else $error("energy total decreased");

   a_phase_advance: assert property (@(posedge clock) disable iff (reset)
      step |=> cycle_phase_ff == PHASE_W'($past(cycle_phase_ff) + 1'b1))
      else $error("cycle phase did not advance");

endmodule

`default_nettype wire

>>> rtl/core/solar_duty_ramp_controller.sv
// ----------------------------------------------------------------------------
// solar_duty_ramp_controller
// Per-line-cycle duty controller for a solar-fed bridge: ramps on time,
// trips on low voltage, heat or energy, drives fan and LED bar.
// ----------------------------------------------------------------------------
// Pipeline: the input register captures a request transaction at its accepting
//   edge and the result register loads from it when the core steps, which a
//   response stall can hold off; the response is valid once it has loaded.
// Throughput: one transaction per cycle; the input register refills while
//   the result register drains. A response stall holds both stages.
// Reset: synchronous; clears both stages, cycle phase, duty, energy total
//   and stored temperature, and loads the default configuration.
`default_nettype none

module solar_duty_ramp_controller
   import sdr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [7:0]             req_solar_sample,
   input  wire logic [7:0]             req_temp_sample,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [7:0]                  rsp_on_time,
   output logic [7:0]                  rsp_off_time,
   output logic                        rsp_fan_run,
   output logic [3:0]                  rsp_led_bar,
   input  wire logic                   csr_wr_en,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type    cfg;
   result_type result;
   result_type result_ff;

   logic       in_valid_ff;
   logic [7:0] solar_ff;
   logic [7:0] temp_ff;
   logic       out_valid_ff;
   logic       out_free;
   logic       step;
   logic       req_take;

   assign out_free  = !out_valid_ff || !rsp_stall;
   assign step      = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign req_take  = req_valid && !req_stall;

   sdr_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   sdr_core u_core (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .solar_sample (solar_ff),
      .temp_sample  (temp_ff),
      .cfg          (cfg),
      .result       (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_take) begin
            in_valid_ff <= 1'b1;
         end else if (step) begin
            in_valid_ff <= 1'b0;
         end
         if (step) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         solar_ff <= '0;
         temp_ff  <= '0;
      end else if (req_take) begin
         solar_ff <= req_solar_sample;
         temp_ff  <= req_temp_sample;
      end
      if (step) begin
         result_ff <= result;
      end
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_on_time  = result_ff.on_time;
   assign rsp_off_time = result_ff.off_time;
   assign rsp_fan_run  = result_ff.fan_run;
   assign rsp_led_bar  = result_ff.led_bar;

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && rsp_stall |=> out_valid_ff && $stable(result_ff))
      else $error("held response overwritten");

   a_take_when_full: assert property (@(posedge clock) disable iff (reset)
      req_take && in_valid_ff |-> step)
      else $error("input register overwritten before step");

   a_step_fills_output: assert property (@(posedge clock) disable iff (reset)
      step |=> out_valid_ff)
      else $error("step did not load response register");

endmodule

`default_nettype wire
